FILE: hw/rtl/pvd_pkg.sv
// Shared constants for the peak and valley detector.
// Default widths, hysteresis width and configuration register indexes.
// No dependencies.
`default_nettype none

package pvd_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF  = 32;

  // Hysteresis register width, fixed by the register map
  localparam int HYST_BITS       = 23;

  // Configuration port
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = HYST_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS      = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_WITH_PEAK = 1'd1;

endpackage

`default_nettype wire

FILE: hw/rtl/pvd_in_stage.sv
// Input register stage: captures sample and index from the input stream.
// Uses pvd_pkg only for consistency of widths handed down by the top level.
`default_nettype none

module pvd_in_stage #(
  parameter int SAMPLE_BITS = pvd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = pvd_pkg::INDEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic        [INDEX_BITS-1:0]  in_index,
  input  wire logic                          take,      // downstream consumes held item
  output logic                               held_valid,
  output logic signed      [SAMPLE_BITS-1:0] sample,
  output logic             [INDEX_BITS-1:0]  sample_index
);
  import pvd_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sample       <= in_sample;
      sample_index <= in_index;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pvd_track.sv
// Extreme tracker: running max/min with positions, direction and the
// hysteresis decision. Result is combinational from the held item.
// Depends on pvd_pkg for the hysteresis width.
`default_nettype none

module pvd_track #(
  parameter int SAMPLE_BITS = pvd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = pvd_pkg::INDEX_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic signed [SAMPLE_BITS-1:0]    sample,
  input  wire logic        [INDEX_BITS-1:0]     sample_index,
  input  wire logic        [pvd_pkg::HYST_BITS-1:0] hysteresis,
  input  wire logic                             start_with_peak,
  output logic                                  found,
  output logic                                  is_maximum,
  output logic signed      [SAMPLE_BITS-1:0]    extreme_value,
  output logic             [INDEX_BITS-1:0]     extreme_index
);
  import pvd_pkg::*;

  // wide enough that s + h and min + h never wrap
  localparam int CMP_BITS = ((SAMPLE_BITS > HYST_BITS) ? SAMPLE_BITS : HYST_BITS) + 2;

  logic                          seeded;
  logic                          seeking_peak;
  logic signed [SAMPLE_BITS-1:0] running_max;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic        [INDEX_BITS-1:0]  max_position;
  logic        [INDEX_BITS-1:0]  min_position;

  logic signed [SAMPLE_BITS-1:0] max_cur, min_cur, max_upd, min_upd;
  logic        [INDEX_BITS-1:0]  maxp_cur, minp_cur, maxp_upd, minp_upd;
  logic                          dir_cur;
  logic signed [CMP_BITS-1:0]    s_ext, h_ext, max_ext, min_ext;
  logic                          peak_hit, valley_hit;

  logic signed [SAMPLE_BITS-1:0] running_max_next, running_min_next;
  logic        [INDEX_BITS-1:0]  max_position_next, min_position_next;
  logic                          seeking_peak_next;

  always_comb begin
    // first item after reset seeds the tracker
    max_cur  = seeded ? running_max  : sample;
    min_cur  = seeded ? running_min  : sample;
    maxp_cur = seeded ? max_position : sample_index;
    minp_cur = seeded ? min_position : sample_index;
    dir_cur  = seeded ? seeking_peak : start_with_peak;

    // strictly larger / smaller replaces
    if (sample > max_cur) begin
      max_upd  = sample;
      maxp_upd = sample_index;
    end else begin
      max_upd  = max_cur;
      maxp_upd = maxp_cur;
    end
    if (sample < min_cur) begin
      min_upd  = sample;
      minp_upd = sample_index;
    end else begin
      min_upd  = min_cur;
      minp_upd = minp_cur;
    end

    s_ext   = CMP_BITS'(sample);
    max_ext = CMP_BITS'(max_upd);
    min_ext = CMP_BITS'(min_upd);
    h_ext   = $signed(CMP_BITS'(hysteresis));

    // s < max - h  is  s + h < max
    peak_hit   = dir_cur && ((s_ext + h_ext) < max_ext);
    valley_hit = !dir_cur && (s_ext > (min_ext + h_ext));

    running_max_next  = max_upd;
    running_min_next  = min_upd;
    max_position_next = maxp_upd;
    min_position_next = minp_upd;
    seeking_peak_next = dir_cur;

    found         = 1'b0;
    is_maximum    = 1'b0;
    extreme_value = '0;
    extreme_index = '0;

    if (peak_hit) begin
      seeking_peak_next = 1'b0;
      running_min_next  = max_upd;
      min_position_next = maxp_upd;
      found             = 1'b1;
      is_maximum        = 1'b1;
      extreme_value     = max_upd;
      extreme_index     = maxp_upd;
    end else if (valley_hit) begin
      seeking_peak_next = 1'b1;
      running_max_next  = min_upd;
      max_position_next = minp_upd;
      found             = 1'b1;
      extreme_value     = min_upd;
      extreme_index     = minp_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded       <= 1'b0;
      seeking_peak <= 1'b0;
    end else if (step) begin
      seeded       <= 1'b1;
      seeking_peak <= seeking_peak_next;
    end
  end

  // tracker values are ignored until seeded, so no reset
  always_ff @(posedge clk) begin
    if (step) begin
      running_max  <= running_max_next;
      running_min  <= running_min_next;
      max_position <= max_position_next;
      min_position <= min_position_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/peak_valley_detector.sv
// Peak and valley detector with hysteresis, top level.
// Holds the configuration registers and the result register.
// Depends on pvd_pkg, pvd_in_stage and pvd_track.
//
// Usage:
//   Input stream s_axis: one sample with its stream index per item. Every
//   accepted item yields exactly one result item on m_axis; tuser[0] (found)
//   says whether that sample confirmed a peak or valley, tuser[1] which kind.
//   Extreme value and index are zero when nothing was found.
//   Path: an accepted item goes into the input register, then the tracker
//   decision on it goes into the result register, where it becomes valid.
//   Throughput: one item per cycle while m_axis is not held off; the tracker
//   state is read and written combinationally between the two registers,
//   so consecutive items chain.
//   Stall: if m_axis is held off, the result register keeps its item and the
//   input register still fills, then s_axis_tready drops until the result
//   is taken. Nothing is lost or repeated.
//   Reset (rst, synchronous): clears both stages, the tracker's seeded flag
//   and sets hysteresis to 0 and start_with_peak to 1. The first item after
//   reset seeds the running max/min and direction.
//   Configuration: cfg_we writes cfg_data to register cfg_index in that cycle
//   (0 hysteresis, 1 start_with_peak); write only while the block is idle.
//   start_with_peak matters only for the first item after reset.
`default_nettype none

module peak_valley_detector #(
  parameter int SAMPLE_BITS = pvd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = pvd_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  // configuration
  input  wire logic                                       cfg_we,
  input  wire logic [pvd_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
  input  wire logic [pvd_pkg::CFG_DATA_BITS-1:0]          cfg_data,
  // input stream
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  // tdata: sample, sample_index (zero pad to bytes)
  input  wire logic [((SAMPLE_BITS+INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result stream
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  // tdata: extreme_value, extreme_index (zero pad to bytes)
  output logic [((SAMPLE_BITS+INDEX_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // tuser: found, is_maximum
  output logic [1:0]                                      m_axis_tuser
);
  import pvd_pkg::*;

  localparam int DATA_BITS = ((SAMPLE_BITS + INDEX_BITS + 7) / 8) * 8;
  localparam int PAD_BITS  = DATA_BITS - SAMPLE_BITS - INDEX_BITS;

  logic [HYST_BITS-1:0] hysteresis;
  logic                 start_with_peak;

  logic                          held_valid;
  logic                          take;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [INDEX_BITS-1:0]  sample_index;

  logic                          found, is_maximum;
  logic signed [SAMPLE_BITS-1:0] extreme_value;
  logic        [INDEX_BITS-1:0]  extreme_index;

  logic                          res_found, res_is_maximum;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic        [INDEX_BITS-1:0]  res_index;

  // configuration registers; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis      <= '0;
      start_with_peak <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HYSTERESIS:      hysteresis      <= cfg_data[HYST_BITS-1:0];
        REG_START_WITH_PEAK: start_with_peak <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // held item moves on when the result register is empty or being drained
  assign take = held_valid && (!m_axis_tvalid || m_axis_tready);

  pvd_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_index     (s_axis_tdata[SAMPLE_BITS+INDEX_BITS-1:SAMPLE_BITS]),
    .take         (take),
    .held_valid   (held_valid),
    .sample       (sample),
    .sample_index (sample_index)
  );

  pvd_track #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_track (
    .clk             (clk),
    .rst             (rst),
    .step            (take),
    .sample          (sample),
    .sample_index    (sample_index),
    .hysteresis      (hysteresis),
    .start_with_peak (start_with_peak),
    .found           (found),
    .is_maximum      (is_maximum),
    .extreme_value   (extreme_value),
    .extreme_index   (extreme_index)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_found      <= found;
      res_is_maximum <= is_maximum;
      res_value      <= extreme_value;
      res_index      <= extreme_index;
    end
  end

  generate
    if (PAD_BITS > 0) begin : g_pad
      assign m_axis_tdata = {{PAD_BITS{1'b0}}, res_index, res_value};
    end else begin : g_nopad
      assign m_axis_tdata = {res_index, res_value};
    end
  endgenerate

  assign m_axis_tuser = {res_is_maximum, res_found};

endmodule

`default_nettype wire

FILE: bench/peak_valley_detector_tb.sv
// Self-checking testbench for peak_valley_detector.
// Drives samples on s_axis, checks results on m_axis against an in-bench tracker model.
// Depends on pvd_pkg and the peak_valley_detector RTL.
`timescale 1ns / 100ps

module peak_valley_detector_tb;
  import pvd_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int IB           = INDEX_BITS_DEF;
  localparam int DW           = ((SB + IB + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1930;
  localparam int HOLD_OFF     = 80;    // long receiver stall, in cycles
  localparam int HOLD_AFTER   = 400;   // items accepted before the long stall
  localparam int WATCHDOG     = 2000;  // cycles with no handshake at all
  localparam int SETTLE       = 4;     // pipeline is two deep; a little margin
  localparam longint SMP_MAX  = 64'sd8388607;
  localparam longint SMP_MIN  = -64'sd8388608;

  // one result item as the bench sees it
  typedef struct packed {
    logic                 found;
    logic                 is_max;
    logic signed [SB-1:0] value;
    logic [IB-1:0]        index;
  } extreme_t;

  localparam extreme_t NO_EXTREME = '0;

  typedef enum logic [1:0] {ROW_ITEM, ROW_HYST, ROW_START} row_kind_e;

  // directed row: an item (value = sample index) or a register write (value = data)
  typedef struct packed {
    row_kind_e            kind;
    logic signed [SB-1:0] sample;
    logic [IB-1:0]        value;
    logic                 typed;
    extreme_t             exp;
  } row_t;

  // Directed walk. Only the first item has its result typed in: with zero
  // hysteresis the seeding sample cannot confirm anything, whichever way the
  // search starts. Everything else goes through the tracker model.
  localparam row_t DIRECTED [0:22] = '{
    // seeding sample
    '{ROW_ITEM,  24'sd0,       32'd0,          1'b1, NO_EXTREME},
    // full-scale swing with zero hysteresis, equal samples held
    '{ROW_ITEM,  24'sh7FFFFF,  32'd1,          1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sh7FFFFF,  32'd2,          1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sh800000,  32'd3,          1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sh800000,  32'd4,          1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd0,       32'd5,          1'b0, NO_EXTREME},
    // largest hysteresis: bounds fall outside the sample range
    '{ROW_HYST,  24'sd0,       32'h007FFFFF,   1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sh7FFFFF,  32'hFFFFFFFF,   1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sh800000,  32'h00000000,   1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sh7FFFFF,  32'hAAAAAAAA,   1'b0, NO_EXTREME},
    '{ROW_ITEM,  -24'sd1,      32'h55555555,   1'b0, NO_EXTREME},
    // sample landing exactly on the bound, then one step past it
    '{ROW_HYST,  24'sd0,       32'd100,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd1000,    32'd100,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd900,     32'd101,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd899,     32'd102,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd999,     32'd103,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd1000,    32'd104,        1'b0, NO_EXTREME},
    // direction register written after seeding: must change nothing
    '{ROW_START, 24'sd0,       32'd0,          1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd500,     32'd105,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd1234,    32'd106,        1'b0, NO_EXTREME},
    '{ROW_HYST,  24'sd0,       32'd0,          1'b0, NO_EXTREME},
    '{ROW_ITEM,  -24'sd5,      32'd107,        1'b0, NO_EXTREME},
    '{ROW_ITEM,  24'sd5,       32'd108,        1'b0, NO_EXTREME}
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [DW-1:0]              s_axis_tdata;   // sample, sample_index
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [DW-1:0]              m_axis_tdata;   // extreme_value, extreme_index
  logic [1:0]                 m_axis_tuser;   // found, is_maximum

  peak_valley_detector dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // tracker model state, mirrors the block's registers
  logic signed [SB-1:0]  trk_max;
  logic signed [SB-1:0]  trk_min;
  logic [IB-1:0]         trk_max_at;
  logic [IB-1:0]         trk_min_at;
  logic                  trk_seek_peak;
  logic                  trk_seeded;
  logic [HYST_BITS-1:0]  cur_hyst;
  logic                  cur_start_peak;

  extreme_t pending_extremes [$];

  int items_in;
  int results_out;
  int peaks_seen;
  int valleys_seen;
  int hyst_settings;
  int mismatches;
  int burst_left;
  int idle_cycles;
  bit held_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected result for one accepted sample; advances the model state.
  function automatic extreme_t predict_extreme(input logic signed [SB-1:0] smp,
                                               input logic [IB-1:0] at);
    extreme_t r;
    int       smp_i;
    r     = NO_EXTREME;
    smp_i = smp;
    if (!trk_seeded) begin
      trk_max       = smp;
      trk_min       = smp;
      trk_max_at    = at;
      trk_min_at    = at;
      trk_seek_peak = cur_start_peak;
      trk_seeded    = 1'b1;
    end
    // strict compares: a repeated extreme keeps its first index
    if (smp > trk_max) begin
      trk_max    = smp;
      trk_max_at = at;
    end
    if (smp < trk_min) begin
      trk_min    = smp;
      trk_min_at = at;
    end
    // bounds worked out in 32 bits so they never wrap
    if (trk_seek_peak && smp_i < int'(trk_max) - int'(cur_hyst)) begin
      trk_seek_peak = 1'b0;
      trk_min       = trk_max;
      trk_min_at    = trk_max_at;
      r.found       = 1'b1;
      r.is_max      = 1'b1;
      r.value       = trk_max;
      r.index       = trk_max_at;
    end else if (!trk_seek_peak && smp_i > int'(trk_min) + int'(cur_hyst)) begin
      trk_seek_peak = 1'b1;
      trk_max       = trk_min;
      trk_max_at    = trk_min_at;
      r.found       = 1'b1;
      r.is_max      = 1'b0;
      r.value       = trk_min;
      r.index       = trk_min_at;
    end
    return r;
  endfunction

  function automatic longint clamp_sample(input longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", results_out, what, got, want);
    mismatches++;
  endtask

  // Offers one item, waits for it to be taken, then applies the sender's
  // burst/gap pacing. tvalid is only lowered when a gap follows.
  task automatic send_item(input logic signed [SB-1:0] smp, input logic [IB-1:0] at,
                           input logic typed, input extreme_t typed_exp);
    extreme_t e;
    int       gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DW'({at, smp});
    do @(posedge clk); while (!s_axis_tready);
    e = predict_extreme(smp, at);
    pending_extremes.push_back(typed ? typed_exp : e);
    items_in++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Stop offering, let every result come out, then give the pipe a moment.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_extremes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_HYSTERESIS) begin
      cur_hyst = data[HYST_BITS-1:0];
      hyst_settings++;
    end else if (idx == REG_START_WITH_PEAK) begin
      cur_start_peak = data[0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: switches between random stall patterns, and holds off
  // once for a long stretch so the block fills and backs up its input.
  initial begin
    int         mode;
    int         left;
    logic [7:0] pat;
    m_axis_tready = 1'b0;
    left          = 0;
    mode          = 0;
    pat           = 8'h01;
    forever begin
      @(posedge clk);
      if (!held_off && items_in >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        held_off = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          pat  = 8'($urandom_range(1, 255));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 9) != 0);
          end
        endcase
      end
    end
  end

  // Result checker: oldest expectation against each accepted result item.
  always @(posedge clk) begin
    extreme_t want;
    extreme_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found  = m_axis_tuser[0];
      got.is_max = m_axis_tuser[1];
      got.value  = m_axis_tdata[SB-1:0];
      got.index  = m_axis_tdata[SB+IB-1:SB];
      if (pending_extremes.size() == 0) begin
        report_mismatch("unexpected result item", longint'(got.found), 0);
      end else begin
        want = pending_extremes.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", longint'(got.found), longint'(want.found));
        if (got.is_max !== want.is_max)
          report_mismatch("is_maximum", longint'(got.is_max), longint'(want.is_max));
        if (got.value !== want.value)
          report_mismatch("extreme_value", longint'(got.value), longint'(want.value));
        if (got.index !== want.index)
          report_mismatch("extreme_index", longint'(got.index), longint'(want.index));
        if (want.found && want.is_max) peaks_seen++;
        if (want.found && !want.is_max) valleys_seen++;
      end
      results_out++;
    end
  end

  // Watchdog: ends the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results still due",
               WATCHDOG, pending_extremes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    longint               cur;
    longint               target;
    longint               span;
    longint               stepmax;
    longint               step;
    int                   dir;
    int                   roll;
    int                   phase_len;
    int                   random_sent;
    logic [HYST_BITS-1:0] h;
    logic signed [SB-1:0] smp;
    logic [IB-1:0]        idx_ctr;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    trk_max        = '0;
    trk_min        = '0;
    trk_max_at     = '0;
    trk_min_at     = '0;
    trk_seek_peak  = 1'b0;
    trk_seeded     = 1'b0;
    cur_hyst       = '0;
    cur_start_peak = 1'b1;
    items_in       = 0;
    results_out    = 0;
    peaks_seen     = 0;
    valleys_seen   = 0;
    hyst_settings  = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    held_off       = 1'b0;
    burst_left     = $urandom_range(1, 40);
    random_sent    = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Only the write before the first item counts, so the seed picks
    // whether this run hunts a peak or a valley first.
    write_reg(REG_START_WITH_PEAK, CFG_DATA_BITS'($urandom_range(0, 1)));

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_HYST: begin
          write_reg(REG_HYSTERESIS, DIRECTED[i].value[CFG_DATA_BITS-1:0]);
        end
        ROW_START: begin
          write_reg(REG_START_WITH_PEAK, DIRECTED[i].value[CFG_DATA_BITS-1:0]);
        end
        default: begin
          send_item(DIRECTED[i].sample, DIRECTED[i].value, DIRECTED[i].typed,
                    DIRECTED[i].exp);
        end
      endcase
    end

    // Random phases: each picks a hysteresis, then plays a wandering signal
    // whose swings straddle it, with flat runs and some raw noise mixed in.
    cur     = 0;
    target  = 0;
    dir     = 1;
    idx_ctr = IB'($urandom());
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       h = '0;
        1:       h = HYST_BITS'(1);
        2:       h = HYST_BITS'($urandom_range(2, 255));
        3:       h = HYST_BITS'($urandom_range(256, 65535));
        4:       h = '1;
        default: h = HYST_BITS'($urandom());
      endcase
      write_reg(REG_HYSTERESIS, CFG_DATA_BITS'(h));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_START_WITH_PEAK, CFG_DATA_BITS'($urandom_range(0, 1)));

      span    = longint'(h) + $urandom_range(1, 5000);
      if ($urandom_range(0, 1) == 1) span = span + longint'(h);
      stepmax = span / $urandom_range(2, 16) + 1;
      target  = cur;
      phase_len = $urandom_range(120, 280);

      for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          smp = SB'($urandom());
        end else begin
          if (cur == target) begin
            dir    = -dir;
            target = clamp_sample(cur + dir * (span / 2 + $urandom_range(0, int'(span))));
          end
          if (roll >= 15) begin
            step = $urandom_range(1, int'(stepmax));
            // small backward wobble now and then
            if (roll >= 90) begin
              cur = clamp_sample(cur - ((target > cur) ? step / 4 : -(step / 4)));
            end else if ((target > cur ? target - cur : cur - target) <= step) begin
              cur = target;
            end else begin
              cur = (target > cur) ? cur + step : cur - step;
            end
          end
          smp = SB'(cur);
        end
        if (roll >= 95) idx_ctr = IB'($urandom());
        else            idx_ctr = idx_ctr + 1'b1;
        send_item(smp, idx_ctr, 1'b0, NO_EXTREME);
        random_sent++;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Run covered %0d items over %0d hysteresis settings, with stalls on both sides.",
             items_in, hyst_settings);
    $display("Results: %0d checked, %0d peaks, %0d valleys, %0d mismatches.",
             results_out, peaks_seen, valleys_seen, mismatches);
    if (mismatches == 0 && pending_extremes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
